// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared macros for the concurrent checks in the sampler modules. They
// expect a clock named i_clk and an active-low reset named i_rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("Assertion failed in the sampler control.");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("Assertion failed in the sampler control.");

`endif

// ===== design/cdt_pkg.sv =====
// ----------------------------------------------------------------------------
// CDT sampler package
// Field widths, codes, state type and the structs shared by the modules of
// the cumulative table Gaussian sampler.
// ----------------------------------------------------------------------------
package cdt_pkg;

    localparam int CNT_W     = 9;
    localparam int IDX_W     = 8;
    localparam int FIELD_W   = 64;
    localparam int SAMPLE_W  = 9;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 9;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_DRAW  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_COUNT = 1'b1;

    localparam logic [CNT_W-1:0] COUNT_RESET = 9'd256;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FOLD,
        S_PROBE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic             signed_mode;
        logic [CNT_W-1:0] table_count;
    } t_cfg;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_value;
        logic                       out_of_range;
    } t_result;

    function automatic logic [CNT_W-1:0] mid_of(input logic [CNT_W-1:0] lo,
                                                input logic [CNT_W-1:0] hi);
        logic [CNT_W:0] sum;
        sum = {1'b0, lo} + {1'b0, hi};
        return sum[CNT_W:1];
    endfunction

endpackage

// ===== design/cdt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with the read data registered.
// ----------------------------------------------------------------------------
module cdt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/cdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// CDT sampler control
// Takes input transfers, writes table entries and runs the bisection with
// one table read per cycle through the RAM read port.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cdt_ctrl
    import cdt_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int ENTRY_WIDTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_cfg                           i_cfg,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_op,
    input  logic [IDX_W-1:0]               i_entry_index,
    input  logic [FIELD_W-1:0]             i_entry_value,
    input  logic [FIELD_W-1:0]             i_random_value,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output t_result                        o_res,
    output logic                           o_ram_we,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_ram_waddr,
    output logic [ENTRY_WIDTH-1:0]         o_ram_wdata,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_ram_raddr,
    input  logic [ENTRY_WIDTH-1:0]         i_ram_rdata
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int XW = AW + CNT_W;
    localparam logic [XW-1:0] DEPTH_X = XW'(TABLE_DEPTH);

    t_state                 r_state, n_state;
    logic [ENTRY_WIDTH-1:0] r_word, n_word;
    logic [CNT_W-1:0]       r_lo, n_lo;
    logic [CNT_W-1:0]       r_hi, n_hi;
    logic                   r_neg, n_neg;
    logic                   r_beyond, n_beyond;

    logic                   accept;
    logic [XW-1:0]          count_x;
    logic [XW-1:0]          active_x;
    logic [CNT_W-1:0]       active;
    logic [CNT_W-1:0]       last;
    logic [CNT_W-1:0]       mid_cur;
    logic [CNT_W-1:0]       mid_next;
    logic [XW-1:0]          raddr_x;
    logic [XW-1:0]          waddr_x;
    logic                   fold;
    logic [ENTRY_WIDTH-1:0] folded;
    logic [CNT_W-1:0]       span;
    logic [CNT_W-1:0]       magnitude;

    assign accept = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        count_x = XW'(i_cfg.table_count);
        if (count_x == '0) begin
            active_x = XW'(1);
        end else if (count_x > DEPTH_X) begin
            active_x = DEPTH_X;
        end else begin
            active_x = count_x;
        end
    end

    assign active  = active_x[CNT_W-1:0];
    assign last    = active - CNT_W'(1);
    assign mid_cur = mid_of(r_lo, r_hi);

    assign waddr_x     = XW'(i_entry_index);
    assign o_ram_we    = accept && (i_op == OP_WRITE) && (waddr_x < DEPTH_X);
    assign o_ram_waddr = waddr_x[AW-1:0];
    assign o_ram_wdata = i_entry_value[ENTRY_WIDTH-1:0];

    always_comb begin
        n_word   = r_word;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_neg    = r_neg;
        n_beyond = r_beyond;
        fold     = 1'b0;
        folded   = r_word;
        unique case (r_state)
            S_IDLE: begin
                n_word   = i_random_value[ENTRY_WIDTH-1:0];
                n_lo     = '0;
                n_hi     = active;
                n_neg    = 1'b0;
                n_beyond = 1'b0;
            end
            S_FOLD: begin
                fold     = i_cfg.signed_mode && (r_word >= i_ram_rdata);
                folded   = fold ? (r_word - i_ram_rdata) : r_word;
                n_word   = folded;
                n_neg    = fold;
                n_beyond = (folded >= i_ram_rdata);
                if (n_beyond) begin
                    n_lo = last;
                end
            end
            S_PROBE: begin
                if (r_word < i_ram_rdata) begin
                    n_hi = mid_cur;
                end else begin
                    n_lo = mid_cur;
                end
            end
            S_EMIT: begin
            end
        endcase
    end

    assign span     = n_hi - n_lo;
    assign mid_next = mid_of(n_lo, n_hi);

    always_comb begin
        raddr_x = (r_state == S_IDLE) ? XW'(last) : XW'(mid_next);
        o_ram_raddr = raddr_x[AW-1:0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_op == OP_DRAW)) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD, S_PROBE: begin
                n_state = (span > CNT_W'(1)) ? S_PROBE : S_EMIT;
            end
            S_EMIT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    assign magnitude          = r_lo;
    assign o_res_valid        = (r_state == S_EMIT);
    assign o_res.sample_value = r_neg ? -$signed(magnitude) : $signed(magnitude);
    assign o_res.out_of_range = r_beyond;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_word   <= n_word;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_neg    <= n_neg;
        r_beyond <= n_beyond;
    end

    `ASSERT_SAME(a_probe_span, r_state == S_PROBE, (r_hi - r_lo) > CNT_W'(1))
    `ASSERT_SAME(a_emit_single, r_state == S_EMIT, r_hi == (r_lo + CNT_W'(1)))
    `ASSERT_NEXT(a_emit_done, (r_state == S_EMIT) && i_res_ready, r_state == S_IDLE)
    `ASSERT_SAME(a_write_idle, o_ram_we, (r_state == S_IDLE) && (i_op == OP_WRITE))

endmodule

// ===== design/cdt_gaussian_sampler.sv =====
// ----------------------------------------------------------------------------
// CDT Gaussian sampler
// Discrete Gaussian sampler that bisects a cumulative table held in RAM.
//
//   Channel   Direction  Handshake           Payload
//   input     in         i_valid / o_stall   i_op, i_entry_index, i_entry_value,
//                                            i_random_value
//   result    out        o_valid / i_stall   o_sample_value, o_out_of_range
//   config    in         i_cfg_we            i_cfg_index, i_cfg_data
//
// A table write goes to the RAM in the cycle of its transfer. A draw reads the
// last table entry, then bisects with one table read per cycle on the single
// RAM read port until its result reaches the output register; a word that is
// out of range skips the bisection. The input stalls meanwhile, so no new
// transfer is taken while a draw is in progress. The control and configuration
// registers use a synchronous active-low reset; the table content is undefined
// until written. A stalled result holds in the output register while the next
// input transfer is taken.
// ----------------------------------------------------------------------------
module cdt_gaussian_sampler
    import cdt_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int ENTRY_WIDTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DAT_W-1:0]       i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_op,
    input  logic [IDX_W-1:0]           i_entry_index,
    input  logic [FIELD_W-1:0]         i_entry_value,
    input  logic [FIELD_W-1:0]         i_random_value,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [SAMPLE_W-1:0] o_sample_value,
    output logic                       o_out_of_range
);

    localparam int AW = $clog2(TABLE_DEPTH);

    t_cfg                        r_cfg;
    logic                        r_out_valid;
    logic signed [SAMPLE_W-1:0]  r_sample_value;
    logic                        r_out_of_range;

    logic                        res_valid;
    logic                        res_ready;
    t_result                     res;
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [ENTRY_WIDTH-1:0]      ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic [ENTRY_WIDTH-1:0]      ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.signed_mode <= 1'b0;
            r_cfg.table_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SIGNED_MODE: r_cfg.signed_mode <= i_cfg_data[0];
                CFG_TABLE_COUNT: r_cfg.table_count <= i_cfg_data[CNT_W-1:0];
            endcase
        end
    end

    cdt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_entry_index  (i_entry_index),
        .i_entry_value  (i_entry_value),
        .i_random_value (i_random_value),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_res          (res),
        .o_ram_we       (ram_we),
        .o_ram_waddr    (ram_waddr),
        .o_ram_wdata    (ram_wdata),
        .o_ram_raddr    (ram_raddr),
        .i_ram_rdata    (ram_rdata)
    );

    cdt_ram #(
        .WIDTH (ENTRY_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign res_ready = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_valid && res_ready) begin
            r_sample_value <= res.sample_value;
            r_out_of_range <= res.out_of_range;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sample_value = r_sample_value;
    assign o_out_of_range = r_out_of_range;

endmodule

// ===== verif/cdt_sample_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CDT sampler checker
// Watches the configuration port and both channels of the cumulative table
// sampler. It keeps its own copy of the table and registers, works out the
// sample for every draw transfer, and compares each result transfer with the
// oldest outstanding sample.
// ----------------------------------------------------------------------------
module cdt_sample_checker
    import cdt_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DAT_W-1:0]       i_cfg_data,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic                       i_op,
    input  logic [IDX_W-1:0]           i_entry_index,
    input  logic [FIELD_W-1:0]         i_entry_value,
    input  logic [FIELD_W-1:0]         i_random_value,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample_value,
    input  logic                       i_out_of_range,
    output int                         o_fail_count,
    output int                         o_pending
);

    logic [FIELD_W-1:0] cdf_table [TABLE_DEPTH];
    logic               signed_mode_q = 1'b0;
    logic [CNT_W-1:0]   count_q = COUNT_RESET;
    t_result            samples_due [$];
    int                 fails = 0;

    function automatic t_result draw_sample(input logic [FIELD_W-1:0] word_in);
        int unsigned        n;
        int unsigned        lo;
        int unsigned        hi;
        int unsigned        mid;
        logic [FIELD_W-1:0] total;
        logic [FIELD_W-1:0] word;
        logic               negative;
        logic               beyond;
        logic [SAMPLE_W-1:0] mag;
        t_result            r;
        n = count_q;
        if (n < 1) n = 1;
        if (n > TABLE_DEPTH) n = TABLE_DEPTH;
        total = cdf_table[n-1];
        word = word_in;
        negative = 1'b0;
        if (signed_mode_q && word >= total) begin
            negative = 1'b1;
            word = word - total;
        end
        beyond = (word >= total);
        lo = 0;
        hi = n;
        if (beyond) begin
            lo = n - 1;
        end else begin
            while (hi - lo > 1) begin
                mid = (lo + hi) / 2;
                if (word < cdf_table[mid]) hi = mid;
                else lo = mid;
            end
        end
        mag = lo[SAMPLE_W-1:0];
        r.sample_value = negative ? (~mag + 1'b1) : mag;
        r.out_of_range = beyond;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result due;
        if (!i_rst_n) begin
            signed_mode_q = 1'b0;
            count_q = COUNT_RESET;
            samples_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (samples_due.size() == 0) begin
                    if (fails < 10)
                        $display("Unexpected result transfer: sample %0d, out_of_range %0b",
                                 i_sample_value, i_out_of_range);
                    fails++;
                end else begin
                    due = samples_due.pop_front();
                    if (due.sample_value !== i_sample_value
                            || due.out_of_range !== i_out_of_range) begin
                        if (fails < 10)
                            $display("Sample mismatch: expected %0d/%0b, got %0d/%0b",
                                     due.sample_value, due.out_of_range,
                                     i_sample_value, i_out_of_range);
                        fails++;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_SIGNED_MODE) signed_mode_q = i_cfg_data[0];
                else if (i_cfg_index == CFG_TABLE_COUNT) count_q = i_cfg_data[CNT_W-1:0];
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_op == OP_WRITE) cdf_table[i_entry_index] = i_entry_value;
                else samples_due.push_back(draw_sample(i_random_value));
            end
        end
        o_fail_count <= fails;
        o_pending <= samples_due.size();
    end

endmodule

// ===== verif/tb_cdt_gaussian_sampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CDT Gaussian sampler testbench
// Loads cumulative tables and draws samples under many register settings,
// first a directed set of corner cases, then random tables and words with
// random gaps on both channels. The checker beside the block predicts and
// compares every sample.
// ----------------------------------------------------------------------------
module tb_cdt_gaussian_sampler
    import cdt_pkg::*;
();

    localparam int DEPTH        = 256;
    localparam int RANDOM_ITEMS = 600;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic [FIELD_W-1:0] ALL_ONES = '1;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = CFG_SIGNED_MODE;
    logic [CFG_DAT_W-1:0]       i_cfg_data = '0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic                       i_op = OP_WRITE;
    logic [IDX_W-1:0]           i_entry_index = '0;
    logic [FIELD_W-1:0]         i_entry_value = '0;
    logic [FIELD_W-1:0]         i_random_value = '0;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] o_sample_value;
    logic                       o_out_of_range;

    int                 mismatch_total;
    int                 draws_pending;
    int                 cycles = 0;
    logic               calm = 1'b0;
    logic [FIELD_W-1:0] shadow_table [DEPTH];
    logic               side_two = 1'b0;
    int unsigned        active_n = DEPTH;
    int unsigned        loaded_n = 0;
    int                 items_sent = 0;

    always #5 i_clk = ~i_clk;

    cdt_gaussian_sampler DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_entry_index  (i_entry_index),
        .i_entry_value  (i_entry_value),
        .i_random_value (i_random_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sample_value (o_sample_value),
        .o_out_of_range (o_out_of_range)
    );

    cdt_sample_checker #(.TABLE_DEPTH(DEPTH)) sample_watch (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_op           (i_op),
        .i_entry_index  (i_entry_index),
        .i_entry_value  (i_entry_value),
        .i_random_value (i_random_value),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_sample_value (o_sample_value),
        .i_out_of_range (o_out_of_range),
        .o_fail_count   (mismatch_total),
        .o_pending      (draws_pending)
    );

    always @(posedge i_clk) begin
        i_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 25);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("cdt_gaussian_sampler regression: fail");
            $finish;
        end
    end

    function automatic logic [FIELD_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [FIELD_W-1:0] pick_word();
        logic [FIELD_W-1:0] total;
        logic [FIELD_W-1:0] span;
        logic [FIELD_W-1:0] w;
        int unsigned        sel;
        int unsigned        k;
        total = shadow_table[active_n-1];
        sel = $urandom_range(0, 99);
        w = rand64();
        if (sel < 55) begin
            span = total;
            if (side_two) span = total[FIELD_W-1] ? '0 : (total << 1);
            if (span != 0) w = w % span;
        end else if (sel < 85) begin
            k = $urandom_range(0, active_n - 1);
            w = shadow_table[k] + FIELD_W'($urandom_range(0, 2)) - 1'b1;
            if (side_two && $urandom_range(0, 1) != 0) w = w + total;
        end
        return w;
    endfunction

    task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                             input logic [FIELD_W-1:0] ev, input logic [FIELD_W-1:0] rv);
        while (!calm && $urandom_range(0, 99) < 25) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_entry_index <= idx;
        i_entry_value <= ev;
        i_random_value <= rv;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic write_entry(input logic [IDX_W-1:0] idx, input logic [FIELD_W-1:0] val);
        shadow_table[idx] = val;
        send_item(OP_WRITE, idx, val, rand64());
    endtask

    task automatic draw(input logic [FIELD_W-1:0] word);
        send_item(OP_DRAW, IDX_W'($urandom), rand64(), word);
    endtask

    // Waits until every outstanding sample has been transferred, then gives
    // a trailing table write time to land before anything else changes.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (draws_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic two, input logic [CNT_W-1:0] cnt);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_SIGNED_MODE;
        i_cfg_data <= {{(CFG_DAT_W-1){1'b0}}, two};
        @(posedge i_clk);
        i_cfg_index <= CFG_TABLE_COUNT;
        i_cfg_data <= cnt;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        side_two = two;
        active_n = (cnt == 0) ? 1 : (cnt > DEPTH) ? DEPTH : cnt;
    endtask

    // Most tables ascend, with small or wide steps; some are left unsorted.
    task automatic load_table(input int unsigned n);
        logic [FIELD_W-1:0] acc;
        int unsigned        kind;
        kind = $urandom_range(0, 99);
        acc = (kind < 45) ? FIELD_W'($urandom_range(0, 3)) : (rand64() >> 12);
        for (int unsigned k = 0; k < n; k++) begin
            if (kind >= 85)
                acc = ($urandom_range(0, 1) != 0) ? rand64() : FIELD_W'($urandom_range(0, 60));
            write_entry(k[IDX_W-1:0], acc);
            acc = acc + ((kind < 45) ? FIELD_W'($urandom_range(0, 20)) : (rand64() >> 8));
        end
        if (n > loaded_n) loaded_n = n;
    endtask

    initial begin : stimulus
        int          phase;
        int unsigned sel;
        int unsigned ndraw;
        logic [CNT_W-1:0] cnt;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        configure(1'b0, 9'd2);
        write_entry(8'd0, 64'd5);
        write_entry(8'd1, 64'd10);
        loaded_n = 2;
        draw(64'd0);
        draw(64'd5);
        draw(64'd9);
        draw(64'd10);
        draw(ALL_ONES);
        configure(1'b1, 9'd2);
        draw(64'd4);
        draw(64'd10);
        draw(64'd15);
        draw(64'd20);
        draw(ALL_ONES);
        // A count of zero behaves as a single entry.
        configure(1'b1, 9'd0);
        draw(64'd3);
        draw(64'd7);
        draw(64'd12);
        configure(1'b0, 9'd2);
        write_entry(8'd0, 64'd0);
        write_entry(8'd1, ALL_ONES);
        draw(ALL_ONES - 1'b1);
        draw(ALL_ONES);
        configure(1'b1, 9'd2);
        draw(ALL_ONES);
        write_entry(8'd0, 64'd100);
        write_entry(8'd1, 64'd50);
        draw(64'd70);
        draw(64'd120);

        items_sent = 0;
        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (phase == 0) begin
                cnt = 9'd511;
            end else if (phase == 1) begin
                cnt = 9'd256;
            end else begin
                sel = $urandom_range(0, 99);
                if (sel < 60) cnt = CNT_W'($urandom_range(2, 8));
                else if (sel < 85) cnt = CNT_W'($urandom_range(9, 40));
                else if (sel < 95) cnt = CNT_W'($urandom_range(0, 1));
                else cnt = CNT_W'($urandom_range(200, 511));
            end
            calm <= (phase == 1);
            configure(1'($urandom_range(0, 1)), cnt);
            if (active_n > loaded_n || (phase != 1 && $urandom_range(0, 99) < 70))
                load_table(active_n);
            ndraw = (phase < 2) ? 40 : $urandom_range(15, 40);
            repeat (ndraw) begin
                if ($urandom_range(0, 99) < 8)
                    write_entry(IDX_W'($urandom_range(0, DEPTH - 1)), rand64());
                draw(pick_word());
            end
            phase++;
        end

        settle();
        if (mismatch_total == 0) begin
            $display("cdt_gaussian_sampler regression: pass");
        end else begin
            $display("cdt_gaussian_sampler regression: fail");
        end
        $finish;
    end

endmodule

// ===== cdt_gaussian_sampler.f =====
+incdir+design
design/cdt_pkg.sv
design/cdt_ram.sv
design/cdt_ctrl.sv
design/cdt_gaussian_sampler.sv
verif/cdt_sample_checker.sv
verif/tb_cdt_gaussian_sampler.sv
